// ----- rtl/fvn_pkg.sv -----
// Package for the fixed-point vector normalizer.
// It holds the widths, the pipeline state encoding and the lane control struct.
// It has no dependencies.
`default_nettype none
package fvn_pkg;
   localparam int COMP_WIDTH  = 32;
   localparam int RADIX_WIDTH = 5;
   localparam int SQ_WIDTH    = 2 * COMP_WIDTH;           // one square
   localparam int SUM_WIDTH   = SQ_WIDTH + 2;             // sum of three squares
   localparam int VAL_WIDTH   = SUM_WIDTH + 31;           // sum shifted back left
   localparam int ROOT_WIDTH  = (VAL_WIDTH + 1) / 2;      // width of the root
   localparam int ROOT_STEPS  = ROOT_WIDTH;               // one bit pair per cycle
   localparam int DIVD_WIDTH  = COMP_WIDTH + 31;          // |c| << radix
   localparam int CNT_WIDTH   = 7;
   localparam int MAG_WIDTH   = 32;
   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = RADIX_WIDTH'(12);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQUARE = 5'b00010,
      ST_ROOT   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   // Control from the sequencer to the divider lanes.
   typedef struct packed {
      logic load;
      logic step;
   } lane_ctrl_type;
endpackage
`default_nettype wire

// ----- rtl/fixed_vector_normalize.sv -----
// Fixed-point 3D vector normalizer, top level.
// Sequence from the accepting edge to rsp_tvalid: squares, root steps,
// divider load, divide steps and the output register.
// An item is accepted only in idle, so a new item waits until the last one is through.
// A result waits in the output register while the next item is accepted.
// Synchronous active-high reset clears control and sets radix_bits to 12.
// Depends on fvn_pkg, fvn_root and fvn_lane.
`default_nettype none
module fixed_vector_normalize (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [4:0]    csr_data,   // radix_bits
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [95:0]   req_tdata,  // comp_x, comp_y, comp_z
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [127:0]       rsp_tdata,  // magnitude, unit_x, unit_y, unit_z
   output logic               rsp_tuser   // zero_length
);
   import fvn_pkg::*;

   state_type                state_ff;
   logic [RADIX_WIDTH-1:0]   radix_ff;
   logic [CNT_WIDTH-1:0]     cnt_ff;
   logic [COMP_WIDTH-1:0]    comp_ff [3];
   logic [COMP_WIDTH-1:0]    comp_abs [3];
   logic [SQ_WIDTH-1:0]      sq_ff [3];
   logic [VAL_WIDTH-1:0]     val;
   logic [SUM_WIDTH-1:0]     sum;
   logic [ROOT_WIDTH-1:0]    root;
   logic [ROOT_WIDTH-1:0]    mag_ff;
   logic                     root_start;
   lane_ctrl_type            lane_ctrl;
   logic [COMP_WIDTH-1:0]    unit [3];
   logic                     out_valid_ff;
   logic [127:0]             out_data_ff;
   logic                     out_zero_ff;
   logic                     out_free;

   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign root_start = (state_ff == ST_SQUARE);

   // Shifted sum of squares, shifted back left.
   always_comb begin
      sum = SUM_WIDTH'(sq_ff[0] >> radix_ff) + SUM_WIDTH'(sq_ff[1] >> radix_ff)
          + SUM_WIDTH'(sq_ff[2] >> radix_ff);
      val = VAL_WIDTH'(sum) << radix_ff;
   end

   fvn_root u_root (
      .clock(clock), .start(root_start), .value(val), .root(root)
   );

   // The lanes load once the root has run all its steps, then divide.
   assign lane_ctrl = '{
      load: (state_ff == ST_ROOT) && (cnt_ff == CNT_WIDTH'(ROOT_STEPS)),
      step: (state_ff == ST_DIVIDE)
   };

   for (genvar g = 0; g < 3; g++) begin : g_lane
      fvn_lane u_lane (
         .clock(clock), .ctrl(lane_ctrl), .comp(comp_ff[g]), .radix(radix_ff),
         .divisor(mag_ff), .unit(unit[g])
      );
   end

   // Absolute values of the held components.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         comp_abs[i] = comp_ff[i][COMP_WIDTH-1] ? (~comp_ff[i] + 1'b1) : comp_ff[i];
      end
   end

   // Squares; one multiplier per component.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         for (int i = 0; i < 3; i++) begin
            comp_ff[i] <= req_tdata[i*COMP_WIDTH +: COMP_WIDTH];
         end
      end
      if (state_ff == ST_IDLE) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SQ_WIDTH'(comp_abs[i]) * SQ_WIDTH'(comp_abs[i]);
         end
      end
      if (lane_ctrl.load) mag_ff <= root;
   end

   // Sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) radix_ff <= csr_data;
         if (state_ff == ST_DONE && out_free) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_SQUARE;
                  cnt_ff   <= '0;
               end
            end
            ST_SQUARE: begin
               // The squares land first; the root unit then loads from them.
               if (cnt_ff == CNT_WIDTH'(1)) begin
                  state_ff <= ST_ROOT;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_ROOT: begin
               if (cnt_ff == CNT_WIDTH'(ROOT_STEPS)) begin
                  state_ff <= ST_DIVIDE;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DIVIDE: begin
               if (cnt_ff == CNT_WIDTH'(DIVD_WIDTH - 1)) state_ff <= ST_DONE;
               else cnt_ff <= cnt_ff + 1'b1;
            end
            ST_DONE: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Result item: saturated magnitude and the unit components.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         out_zero_ff <= (mag_ff == '0);
         out_data_ff[31:0] <= (|mag_ff[ROOT_WIDTH-1:MAG_WIDTH]) ? '1
                              : mag_ff[MAG_WIDTH-1:0];
         for (int i = 0; i < 3; i++) begin
            out_data_ff[32 + i*32 +: 32] <= (mag_ff == '0) ? '0 : unit[i];
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_zero_ff;

   // A result is never dropped while it waits.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result lost");
   // Items are accepted only while idle.
   a_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("accept while busy");
   // A zero-length result has zero components.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[127:32] == '0) else $error("zero flag");
endmodule
`default_nettype wire

// ----- rtl/fvn_root.sv -----
// Bit-pair integer square root, one pair of bits per cycle.
// Depends on fvn_pkg.
`default_nettype none
module fvn_root (
   input  wire logic                            clock,
   input  wire logic                            start,
   input  wire logic [fvn_pkg::VAL_WIDTH-1:0]   value,
   output logic      [fvn_pkg::ROOT_WIDTH-1:0]  root
);
   import fvn_pkg::*;

   localparam int PAD_WIDTH = 2 * ROOT_WIDTH;

   logic [PAD_WIDTH-1:0]    val_ff, val_in;
   logic [ROOT_WIDTH+1:0]   rem_ff, rem_in;
   logic [ROOT_WIDTH-1:0]   q_ff, q_in;
   logic [ROOT_WIDTH+1:0]   shifted, trial;

   // One iteration: bring in the next pair and try to subtract 4q+1.
   always_comb begin
      shifted = {rem_ff[ROOT_WIDTH-1:0], val_ff[PAD_WIDTH-1 -: 2]};
      trial   = {q_ff, 2'b01};
      val_in  = {val_ff[PAD_WIDTH-3:0], 2'b00};
      if (shifted >= trial) begin
         rem_in = shifted - trial;
         q_in   = {q_ff[ROOT_WIDTH-2:0], 1'b1};
      end else begin
         rem_in = shifted;
         q_in   = {q_ff[ROOT_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff <= PAD_WIDTH'(value);
         rem_ff <= '0;
         q_ff   <= '0;
      end else begin
         val_ff <= val_in;
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign root = q_ff;
endmodule
`default_nettype wire

// ----- rtl/fvn_lane.sv -----
// One divider lane: restoring division of |c| << radix by the magnitude,
// one quotient bit per cycle while step is high, with sign and saturation on the result.
// Depends on fvn_pkg.
`default_nettype none
module fvn_lane (
   input  wire logic                            clock,
   input  wire fvn_pkg::lane_ctrl_type          ctrl,
   input  wire logic [fvn_pkg::COMP_WIDTH-1:0]  comp,
   input  wire logic [fvn_pkg::RADIX_WIDTH-1:0] radix,
   input  wire logic [fvn_pkg::ROOT_WIDTH-1:0]  divisor,
   output logic      [fvn_pkg::COMP_WIDTH-1:0]  unit
);
   import fvn_pkg::*;

   logic                   neg_ff;
   logic [DIVD_WIDTH-1:0]  num_ff, num_in;
   logic [DIVD_WIDTH-1:0]  quo_ff, quo_in;
   logic [ROOT_WIDTH:0]    rem_ff, rem_in;
   logic [ROOT_WIDTH:0]    part;
   logic [COMP_WIDTH-1:0]  mag_abs;
   logic                   big;

   assign mag_abs = comp[COMP_WIDTH-1] ? (~comp + 1'b1) : comp;

   // One restoring step.
   always_comb begin
      part   = {rem_ff[ROOT_WIDTH-1:0], num_ff[DIVD_WIDTH-1]};
      num_in = {num_ff[DIVD_WIDTH-2:0], 1'b0};
      if (part >= {1'b0, divisor}) begin
         rem_in = part - {1'b0, divisor};
         quo_in = {quo_ff[DIVD_WIDTH-2:0], 1'b1};
      end else begin
         rem_in = part;
         quo_in = {quo_ff[DIVD_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         neg_ff <= comp[COMP_WIDTH-1];
         num_ff <= DIVD_WIDTH'(mag_abs) << radix;
         quo_ff <= '0;
         rem_ff <= '0;
      end else if (ctrl.step) begin
         num_ff <= num_in;
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // Saturate to the signed component range.
   always_comb begin
      big = |quo_ff[DIVD_WIDTH-1:COMP_WIDTH-1];
      if (neg_ff) begin
         if (big) unit = {1'b1, {(COMP_WIDTH-1){1'b0}}};
         else     unit = ~quo_ff[COMP_WIDTH-1:0] + 1'b1;
      end else begin
         if (big) unit = {1'b0, {(COMP_WIDTH-1){1'b1}}};
         else     unit = quo_ff[COMP_WIDTH-1:0];
      end
   end
endmodule
`default_nettype wire

// ----- tb/sv/fixed_vector_normalize_checker.sv -----
// Checker for the fixed-point vector normalizer: watches the register,
// request and response channels, predicts each result and compares it.
// Depends on fvn_pkg for the radix width and reset value.
`default_nettype none
module fixed_vector_normalize_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [fvn_pkg::RADIX_WIDTH-1:0] csr_data,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [95:0]                     req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [127:0]                    rsp_tdata,
   input  wire logic                            rsp_tuser,
   output int                                   error_count,
   output int                                   pending_count
);
   import fvn_pkg::*;

   typedef struct packed {
      logic [31:0] magnitude;
      logic [31:0] unit_x;
      logic [31:0] unit_y;
      logic [31:0] unit_z;
      logic        zero_length;
   } norm_result_type;

   norm_result_type       pending_norms[$];
   logic [RADIX_WIDTH-1:0] radix;

   // Floor square root of a 96-bit value, two bits per step.
   function automatic logic [63:0] floor_sqrt96(input logic [95:0] v);
      logic [63:0]  q;
      logic [127:0] r;
      logic [127:0] t;
      q = '0;
      r = '0;
      for (int p = 94; p >= 0; p -= 2) begin
         r = (r << 2) | 128'(v[p +: 2]);
         t = (128'(q) << 2) | 128'd1;
         if (r >= t) begin
            r = r - t;
            q = (q << 1) | 64'd1;
         end else begin
            q = q << 1;
         end
      end
      return q;
   endfunction

   // Scales one component by 2^radix, divides by the length and saturates.
   function automatic logic [31:0] unit_component(input logic signed [31:0] c,
                                                  input logic [4:0] sh,
                                                  input logic [63:0] mag);
      logic [63:0] a;
      logic [63:0] q;
      a = c[31] ? 64'(-64'(c)) : 64'(c);
      q = (a << sh) / mag;
      if (c[31]) begin
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         return 32'(-q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[31:0];
   endfunction

   function automatic norm_result_type normalize(input logic [95:0] data,
                                                 input logic [4:0] sh);
      logic signed [31:0] c[3];
      logic [63:0]        a;
      logic [63:0]        sum;
      logic [95:0]        widened;
      logic [63:0]        mag;
      norm_result_type    res;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         c[i] = data[32*i +: 32];
         a = c[i][31] ? 64'(-64'(c[i])) : 64'(c[i]);
         sum += (a * a) >> sh;
      end
      widened = 96'(sum) << sh;
      mag = floor_sqrt96(widened);
      res.magnitude = (mag > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag[31:0];
      if (mag == 0) begin
         res.unit_x = '0;
         res.unit_y = '0;
         res.unit_z = '0;
         res.zero_length = 1'b1;
      end else begin
         res.unit_x = unit_component(c[0], sh, mag);
         res.unit_y = unit_component(c[1], sh, mag);
         res.unit_z = unit_component(c[2], sh, mag);
         res.zero_length = 1'b0;
      end
      return res;
   endfunction

   // Track the register, queue predictions and compare responses.
   always @(posedge clock) begin
      norm_result_type want;
      norm_result_type got;
      if (reset) begin
         radix <= RADIX_RESET;
         error_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                   rsp_tdata[127:96], rsp_tuser};
            if (pending_norms.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               error_count <= error_count + 1;
            end else begin
               want = pending_norms.pop_front();
               if (want.magnitude !== got.magnitude)
                  $display("%0t: magnitude expected %h actual %h", $time,
                           want.magnitude, got.magnitude);
               if (want.unit_x !== got.unit_x)
                  $display("%0t: unit_x expected %h actual %h", $time,
                           want.unit_x, got.unit_x);
               if (want.unit_y !== got.unit_y)
                  $display("%0t: unit_y expected %h actual %h", $time,
                           want.unit_y, got.unit_y);
               if (want.unit_z !== got.unit_z)
                  $display("%0t: unit_z expected %h actual %h", $time,
                           want.unit_z, got.unit_z);
               if (want.zero_length !== got.zero_length)
                  $display("%0t: zero_length expected %b actual %b", $time,
                           want.zero_length, got.zero_length);
               if (want !== got) error_count <= error_count + 1;
            end
         end
         if (req_tvalid && req_tready)
            pending_norms.push_back(normalize(req_tdata, radix));
         if (csr_valid && csr_ready) radix <= csr_data;
         pending_count <= pending_norms.size();
      end
   end
endmodule
`default_nettype wire

// ----- tb/sv/tb_fixed_vector_normalize.sv -----
// Testbench top for the fixed-point vector normalizer: drives directed and
// random vectors across several radix settings, with random stalls on both sides but for one setting.
// Depends on fvn_pkg, fixed_vector_normalize and fixed_vector_normalize_checker.
`default_nettype none
module tb_fixed_vector_normalize;
   import fvn_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [RADIX_WIDTH-1:0] csr_data = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [95:0]            req_tdata = '0;   // comp_x, comp_y, comp_z
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [127:0]           rsp_tdata;        // magnitude, unit_x, unit_y, unit_z
   logic                   rsp_tuser;        // zero_length
   int                     error_count;
   int                     pending_count;
   bit                     no_stalls = 1'b0;

   always #5 clock = ~clock;

   fixed_vector_normalize dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   fixed_vector_normalize_checker checker_inst (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .error_count(error_count),
      .pending_count(pending_count)
   );

   // Run limit.
   initial begin
      #50_000_000;
      $display("[fixed_vector_normalize] ERROR");
      $finish;
   end

   // Response side: random back-pressure per item.
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = no_stalls ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
      int gap;
      gap = no_stalls ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {z, y, x};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Writes the radix once every pending result has drained.
   task automatic write_radix(input logic [RADIX_WIDTH-1:0] value);
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (120) @(negedge clock);
      csr_valid = 1'b1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // One random component, biased toward small and edge values.
   function automatic logic [31:0] random_component();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'(int'($urandom_range(0, 200)) - 100);
         2: return 32'(1) << $urandom_range(0, 31);
         3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         4: return 32'($signed($urandom()) >>> $urandom_range(8, 28));
         default: return 32'($signed($urandom()) >>> $urandom_range(0, 16));
      endcase
   endfunction

   task automatic send_directed();
      send_vector(0, 0, 0);
      send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'h8000_0000, 0, 0);
      send_vector(0, 32'h7FFF_FFFF, 0);
      send_vector(0, 0, 32'hFFFF_FFFF);
      send_vector(1, 32'hFFFF_FFFF, 1);
      send_vector(32'h1000, 0, 0);
      send_vector(32'hFFFF_F000, 32'h1000, 32'h2000);
      send_vector(32'h3000, 32'h4000, 0);
      send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555);
      send_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F);
   endtask

   initial begin
      logic [RADIX_WIDTH-1:0] radix_plan[6];
      radix_plan = '{5'd0, 5'd31, 5'd30, 5'd1, 5'd20, 5'd16};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset radix first, then the extremes and a few in between.
      send_directed();
      for (int i = 0; i < 120; i++)
         send_vector(random_component(), random_component(), random_component());
      foreach (radix_plan[k]) begin
         write_radix(radix_plan[k]);
         no_stalls = (k == 2);
         send_directed();
         for (int i = 0; i < 100; i++)
            send_vector(random_component(), random_component(),
                        random_component());
      end
      no_stalls = 1'b0;
      write_radix(5'd12);
      for (int i = 0; i < 60; i++)
         send_vector(random_component(), random_component(), random_component());
      req_tvalid = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (150) @(negedge clock);
      if (error_count == 0) begin
         $display("[fixed_vector_normalize] OK");
      end else begin
         $display("[fixed_vector_normalize] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
